/* design/pfd_pkg.sv */
// Shared types, constants and register codes of the ping flood detector.
`default_nettype none

package pfd_pkg;

    // Table depth default
    localparam int PFD_TABLE_ENTRIES = 16;

    // ICMP echo request
    localparam logic [7:0] ECHO_TYPE = 8'd8;
    localparam logic [7:0] ECHO_CODE = 8'd0;

    // Register reset values
    localparam logic [15:0] MIN_PAYLOAD_RESET = 16'd1024;
    localparam logic [15:0] MAX_DELAY_RESET   = 16'd200;
    localparam logic [15:0] MIN_COUNT_RESET   = 16'd100;

    // Register indexes (word address)
    localparam logic [1:0] REG_MIN_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_MAX_DELAY   = 2'd1;
    localparam logic [1:0] REG_MIN_COUNT   = 2'd2;

    typedef struct packed {
        logic [15:0] min_payload;
        logic [15:0] max_delay;
        logic [15:0] min_count;
    } pfd_cfg_t;

    // Search probe that travels down the cell chain
    typedef struct packed {
        logic        vld;
        logic [31:0] target;
        logic        hit;
        logic        free;
        logic [31:0] cnt;
        logic [47:0] sum;
        logic [47:0] last;
    } pfd_probe_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_ALLOC,
        CMD_UPDATE,
        CMD_FREE
    } pfd_cmd_op_t;

    // Write command broadcast to the marked cell
    typedef struct packed {
        pfd_cmd_op_t op;
        logic [31:0] target;
        logic [31:0] cnt;
        logic [47:0] sum;
        logic [47:0] last;
    } pfd_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SUM,
        ST_MUL,
        ST_TEST,
        ST_DONE
    } pfd_state_t;

endpackage

`default_nettype wire

/* design/pfd_if.sv */
// Valid/ready channel interfaces for packet summaries and detection results.
`default_nettype none

interface pfd_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] total_length;
    logic [15:0] hdr_len;
    logic [31:0] dest_ip;
    logic [47:0] arrival_ms;

    modport source (
        output valid, icmp_type, icmp_code, total_length, hdr_len,
               dest_ip, arrival_ms,
        input  ready
    );
    modport sink (
        input  valid, icmp_type, icmp_code, total_length, hdr_len,
               dest_ip, arrival_ms,
        output ready
    );
endinterface

interface pfd_res_if;
    logic valid;
    logic ready;
    logic flood_detected;
    logic new_target;
    logic table_full;

    modport source (
        output valid, flood_detected, new_target, table_full,
        input  ready
    );
    modport sink (
        input  valid, flood_detected, new_target, table_full,
        output ready
    );
endinterface

`default_nettype wire

/* design/pfd_cell.sv */
// One table entry: holds a target's record, checks the passing probe, applies commands.
`default_nettype none

module pfd_cell
    import pfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pfd_probe_t probe_in,
    output pfd_probe_t probe_out,
    input  pfd_cmd_t   cmd
);

    logic        valid_reg, valid_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [47:0] sum_reg, sum_next;
    logic [47:0] last_reg, last_next;
    logic        hit_mark_reg, hit_mark_next;
    logic        free_mark_reg, free_mark_next;
    pfd_probe_t  probe_out_reg, probe_out_next;

    logic match;
    logic free_here;

    assign match     = valid_reg && (addr_reg == probe_in.target) && !probe_in.hit;
    assign free_here = !valid_reg && !probe_in.free;

    always_comb
    begin
        probe_out_next = probe_in;
        hit_mark_next  = hit_mark_reg;
        free_mark_next = free_mark_reg;
        if (probe_in.vld)
        begin
            // mark this cell for the command that follows the search
            hit_mark_next  = match;
            free_mark_next = free_here;
            if (match)
            begin
                probe_out_next.hit  = 1'b1;
                probe_out_next.cnt  = cnt_reg;
                probe_out_next.sum  = sum_reg;
                probe_out_next.last = last_reg;
            end
            else if (free_here)
            begin
                probe_out_next.free = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        last_next  = last_reg;
        case (cmd.op)
            CMD_ALLOC:
            begin
                if (free_mark_reg)
                begin
                    valid_next = 1'b1;
                    addr_next  = cmd.target;
                    cnt_next   = '0;
                    sum_next   = '0;
                    last_next  = cmd.last;
                end
            end
            CMD_UPDATE:
            begin
                if (hit_mark_reg)
                begin
                    cnt_next  = cmd.cnt;
                    sum_next  = cmd.sum;
                    last_next = cmd.last;
                end
            end
            CMD_FREE:
            begin
                if (hit_mark_reg)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            hit_mark_reg  <= 1'b0;
            free_mark_reg <= 1'b0;
            probe_out_reg <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            hit_mark_reg  <= hit_mark_next;
            free_mark_reg <= free_mark_next;
            probe_out_reg <= probe_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        cnt_reg  <= cnt_next;
        sum_reg  <= sum_next;
        last_reg <= last_next;
    end

    assign probe_out = probe_out_reg;

endmodule

`default_nettype wire

/* design/pfd_ctrl.sv */
// Sequencer: filters packets, launches the search, allocates, updates or frees the record and tests for a flood.
`default_nettype none

module pfd_ctrl
    import pfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pfd_pkt_if.sink    pkt,
    pfd_res_if.source  res,
    input  pfd_cfg_t   cfg,
    output pfd_probe_t probe_head,
    input  pfd_probe_t probe_tail,
    output pfd_cmd_t   cmd
);

    pfd_state_t  state_reg, state_next;
    pfd_probe_t  head_reg, head_next;
    pfd_cmd_op_t cmd_op_reg, cmd_op_next;

    logic [31:0] tgt_reg, tgt_next;
    logic [47:0] now_reg, now_next;
    logic [47:0] delta_reg, delta_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [47:0] sum_reg, sum_next;
    logic [47:0] limit_reg, limit_next;

    logic flood_reg, flood_next;
    logic newt_reg, newt_next;
    logic full_reg, full_next;

    logic res_valid_reg, res_valid_next;
    logic res_flood_reg, res_flood_next;
    logic res_newt_reg, res_newt_next;
    logic res_full_reg, res_full_next;

    logic               accept;
    logic               is_echo;
    logic signed [17:0] payload;
    logic signed [17:0] min_payload_s;
    logic [48:0]        sum_ext;

    assign accept        = pkt.valid && pkt.ready;
    assign is_echo       = (pkt.icmp_type == ECHO_TYPE) && (pkt.icmp_code == ECHO_CODE);
    assign payload       = $signed({2'b00, pkt.total_length}) -
                           $signed({2'b00, pkt.hdr_len});
    assign min_payload_s = $signed({2'b00, cfg.min_payload});
    assign sum_ext       = {1'b0, sum_reg} + {1'b0, delta_reg};

    always_comb
    begin
        state_next     = state_reg;
        head_next      = '0;
        cmd_op_next    = CMD_NONE;
        tgt_next       = tgt_reg;
        now_next       = now_reg;
        delta_next     = delta_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        limit_next     = limit_reg;
        flood_next     = flood_reg;
        newt_next      = newt_reg;
        full_next      = full_reg;
        res_valid_next = res_valid_reg;
        res_flood_next = res_flood_reg;
        res_newt_next  = res_newt_reg;
        res_full_next  = res_full_reg;

        // drop the output once its transfer completes
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tgt_next   = pkt.dest_ip;
                    now_next   = pkt.arrival_ms;
                    flood_next = 1'b0;
                    newt_next  = 1'b0;
                    full_next  = 1'b0;
                    if (is_echo && (payload >= min_payload_s))
                    begin
                        head_next.vld    = 1'b1;
                        head_next.target = pkt.dest_ip;
                        state_next       = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (probe_tail.vld)
                begin
                    if (probe_tail.hit)
                    begin
                        delta_next = now_reg - probe_tail.last;
                        sum_next   = probe_tail.sum;
                        cnt_next   = (probe_tail.cnt == 32'hFFFF_FFFF) ? probe_tail.cnt
                                                                      : probe_tail.cnt + 32'd1;
                        state_next = ST_SUM;
                    end
                    else if (probe_tail.free)
                    begin
                        cmd_op_next = CMD_ALLOC;
                        newt_next   = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        full_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SUM:
            begin
                // saturate the delay sum at its full scale
                sum_next   = sum_ext[48] ? {48{1'b1}} : sum_ext[47:0];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                limit_next = {32'd0, cfg.max_delay} * {16'd0, cnt_reg};
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (({16'd0, cfg.min_count} <= cnt_reg) && (sum_reg < limit_reg))
                begin
                    flood_next  = 1'b1;
                    cmd_op_next = CMD_FREE;
                end
                else
                begin
                    cmd_op_next = CMD_UPDATE;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_flood_next = flood_reg;
                    res_newt_next  = newt_reg;
                    res_full_next  = full_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            cmd_op_reg    <= CMD_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cmd_op_reg    <= cmd_op_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg       <= tgt_next;
        now_reg       <= now_next;
        delta_reg     <= delta_next;
        cnt_reg       <= cnt_next;
        sum_reg       <= sum_next;
        limit_reg     <= limit_next;
        flood_reg     <= flood_next;
        newt_reg      <= newt_next;
        full_reg      <= full_next;
        res_flood_reg <= res_flood_next;
        res_newt_reg  <= res_newt_next;
        res_full_reg  <= res_full_next;
    end

    assign pkt.ready          = (state_reg == ST_IDLE);
    assign probe_head         = head_reg;
    assign cmd.op             = cmd_op_reg;
    assign cmd.target         = tgt_reg;
    assign cmd.cnt            = cnt_reg;
    assign cmd.sum            = sum_reg;
    assign cmd.last           = now_reg;
    assign res.valid          = res_valid_reg;
    assign res.flood_detected = res_flood_reg;
    assign res.new_target     = res_newt_reg;
    assign res.table_full     = res_full_reg;

endmodule

`default_nettype wire

/* design/ping_flood_detector.sv */
// Top level of the ping flood detector: register port, cell chain and sequencer.
// Flow: an ignored packet goes straight to the result; a new or refused target waits for
//   the probe to walk the whole chain, and a known target then passes SUM, MUL and TEST.
// Throughput: one packet at a time; the next transfer is taken only after the result is
//   loaded, and loading waits while the previous result is still held. The probe walks
//   down the cell chain one cell per cycle.
// Reset: rst_n clears all valid bits and restores the registers to 1024 / 200 / 100.
`default_nettype none

module ping_flood_detector
    import pfd_pkg::*;
#(
    parameter int TABLE_ENTRIES = PFD_TABLE_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    pfd_pkt_if.sink     pkt,
    pfd_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pfd_cfg_t   cfg_reg, cfg_next;
    pfd_cmd_t   cmd;
    pfd_probe_t probe [0:TABLE_ENTRIES];

    logic       cfg_write;
    logic [1:0] reg_index;

    // Register port: write on the access phase, reads return the held value.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                REG_MIN_PAYLOAD: cfg_next.min_payload = pwdata[15:0];
                REG_MAX_DELAY:   cfg_next.max_delay   = pwdata[15:0];
                REG_MIN_COUNT:   cfg_next.min_count   = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MIN_PAYLOAD: prdata = {16'd0, cfg_reg.min_payload};
            REG_MAX_DELAY:   prdata = {16'd0, cfg_reg.max_delay};
            REG_MIN_COUNT:   prdata = {16'd0, cfg_reg.min_count};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_payload <= MIN_PAYLOAD_RESET;
            cfg_reg.max_delay   <= MAX_DELAY_RESET;
            cfg_reg.min_count   <= MIN_COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: injects the probe at the head, reads it back at the tail,
    // then broadcasts at most one write command to the marked cell.
    pfd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .res        (res),
        .cfg        (cfg_reg),
        .probe_head (probe[0]),
        .probe_tail (probe[TABLE_ENTRIES]),
        .cmd        (cmd)
    );

    // Table: the probe advances one cell per cycle; the first matching valid
    // entry claims the hit, and the first free entry marks itself for
    // allocation.
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        pfd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (probe[i]),
            .probe_out (probe[i+1]),
            .cmd       (cmd)
        );
    end

endmodule

`default_nettype wire

/* verif/ping_flood_detector_test.sv */
// Self-checking testbench for the ping flood detector: directed plan, random phases, APB setup.
`timescale 1ns / 100ps

module ping_flood_detector_test
    import pfd_pkg::*;
;

    // One packet summary as the sender offers it
    typedef struct packed {
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [15:0] total_length;
        logic [15:0] hdr_len;
        logic [31:0] dest_ip;
        logic [47:0] arrival_ms;
    } ping_t;

    // One detection result as the receiver takes it
    typedef struct packed {
        logic flood_detected;
        logic new_target;
        logic table_full;
    } verdict_t;

    // One line of the directed plan: either a register setting or a run of pings
    typedef struct {
        bit       reconfig;
        pfd_cfg_t settings;
        ping_t    ping;
        int       reps;
        bit       typed;
        verdict_t given;
    } plan_row_t;

    localparam verdict_t V_QUIET = '{flood_detected: 1'b0, new_target: 1'b0, table_full: 1'b0};
    localparam verdict_t V_NEW   = '{flood_detected: 1'b0, new_target: 1'b1, table_full: 1'b0};
    localparam verdict_t V_FULL  = '{flood_detected: 1'b0, new_target: 1'b0, table_full: 1'b1};
    localparam verdict_t V_FLOOD = '{flood_detected: 1'b1, new_target: 1'b0, table_full: 1'b0};

    localparam pfd_cfg_t CFG_NONE = '0;
    localparam ping_t    NO_PING  = '0;

    // Index past the last register; writes there must leave the others alone
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam logic [31:0] IP_A   = 32'h0000_0000;
    localparam logic [31:0] IP_B   = 32'hFFFF_FFFF;
    localparam logic [31:0] IP_C   = 32'hC0A8_0001;
    localparam logic [31:0] BASE_D = 32'h0A00_0000;

    localparam int PHASES      = 8;
    localparam int PER_PHASE   = 200;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 1_200_000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pfd_pkt_if pkt ();
    pfd_res_if res ();

    ping_flood_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the register file as the predictor sees it
    logic [15:0] cfg_min_payload;
    logic [15:0] cfg_max_delay;
    logic [15:0] cfg_min_count;

    // Shadow copy of the target table
    logic        tgt_valid [PFD_TABLE_ENTRIES];
    logic [31:0] tgt_addr  [PFD_TABLE_ENTRIES];
    logic [31:0] tgt_count [PFD_TABLE_ENTRIES];
    logic [47:0] tgt_delay [PFD_TABLE_ENTRIES];
    logic [47:0] tgt_last  [PFD_TABLE_ENTRIES];

    // Verdicts owed by the block, oldest first
    verdict_t verdict_q [$];

    plan_row_t plan [$];

    int mismatches;
    int cycles;
    bit quiet;          // no idling on either side while set
    bit hold_off_req;   // ask the receiver for one long stall

    // ------------------------------------------------------------------
    // Clock: 4 ns period
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Watchdog: stop a hung run once the cycle budget is spent
    // ------------------------------------------------------------------
    initial
    begin
        cycles = 0;
        do
        begin
            @(posedge clk);
            cycles++;
        end
        while (cycles <= CYCLE_LIMIT);
        $display("ping_flood_detector test failed");
        $finish;
    end

    // Idle length for either side: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Verdict predictor. Works out the result of one accepted ping and
    // advances the shadow table. counted is low for pings the block drops.
    // ------------------------------------------------------------------
    function automatic verdict_t judge_ping(input ping_t p, output bit counted);
        verdict_t    v;
        int          payload;
        int          hit;
        int          slot;
        logic [47:0] delta;
        logic [48:0] sum_wide;
        logic [31:0] cnt;
        logic [63:0] bound;
        v = V_QUIET;
        hit = -1;
        slot = -1;
        counted = 1'b0;
        // Payload is a signed difference: a header longer than the message
        // gives a negative size, below any minimum
        payload = int'(p.total_length) - int'(p.hdr_len);
        if (p.icmp_type != ECHO_TYPE || p.icmp_code != ECHO_CODE
                || payload < int'(cfg_min_payload))
            return v;
        counted = 1'b1;

        // First live entry with this address, and the lowest free entry
        for (int i = 0; i < PFD_TABLE_ENTRIES; i++)
        begin
            if (tgt_valid[i])
            begin
                if (hit < 0 && tgt_addr[i] == p.dest_ip)
                    hit = i;
            end
            else if (slot < 0)
                slot = i;
        end

        if (hit < 0)
        begin
            if (slot < 0)
                v.table_full = 1'b1;
            else
            begin
                tgt_valid[slot] = 1'b1;
                tgt_addr[slot]  = p.dest_ip;
                tgt_count[slot] = '0;
                tgt_delay[slot] = '0;
                tgt_last[slot]  = p.arrival_ms;
                v.new_target = 1'b1;
            end
            return v;
        end

        // Known target: modular gap, saturating count and sum
        delta = p.arrival_ms - tgt_last[hit];
        sum_wide = {1'b0, tgt_delay[hit]} + {1'b0, delta};
        cnt = tgt_count[hit];
        if (cnt != '1)
            cnt++;
        tgt_count[hit] = cnt;
        tgt_delay[hit] = sum_wide[48] ? '1 : sum_wide[47:0];
        tgt_last[hit]  = p.arrival_ms;

        // Mean below the limit, without a division
        bound = 64'(cfg_max_delay) * 64'(cnt);
        if (cnt >= 32'(cfg_min_count) && 64'(tgt_delay[hit]) < bound)
        begin
            tgt_valid[hit] = 1'b0;
            v.flood_detected = 1'b1;
        end
        return v;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s expected %b got %b", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: idle a random while, offer the ping, hold it until the
    // transfer, then queue what the block owes for it.
    // ------------------------------------------------------------------
    task automatic offer_ping(input ping_t p, input bit typed, input verdict_t given,
                              output bit counted);
        int       gap;
        verdict_t v;
        gap = pick_gap();
        if (gap > 0)
        begin
            pkt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt.valid        <= 1'b1;
        pkt.icmp_type    <= p.icmp_type;
        pkt.icmp_code    <= p.icmp_code;
        pkt.total_length <= p.total_length;
        pkt.hdr_len      <= p.hdr_len;
        pkt.dest_ip      <= p.dest_ip;
        pkt.arrival_ms   <= p.arrival_ms;
        do @(posedge clk); while (pkt.ready !== 1'b1);
        v = judge_ping(p, counted);
        // Rows with a verdict typed in the plan are held to that verdict
        verdict_q.push_back(typed ? given : v);
    endtask

    // ------------------------------------------------------------------
    // APB access: setup phase, access phase held until pready, then idle
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_check(input logic [3:0] addr, input logic [15:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        // Sample read data mid-cycle in the access phase
        do @(negedge clk); while (pready !== 1'b1);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== {16'h0000, want})
        begin
            $display("%0t: register at %h expected %h got %h", $time, addr,
                     {16'h0000, want}, got);
            mismatches++;
        end
    endtask

    // Drain the block, then load all three registers (with junk in the upper
    // half of the bus), poke the unused index and read the three back.
    task automatic apply_settings(input pfd_cfg_t s);
        pkt.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        reg_write({REG_MIN_PAYLOAD, 2'b00}, {16'($urandom()), s.min_payload});
        reg_write({REG_MAX_DELAY, 2'b00},   {16'($urandom()), s.max_delay});
        reg_write({REG_MIN_COUNT, 2'b00},   {16'($urandom()), s.min_count});
        reg_write({REG_SPARE, 2'b00}, $urandom());
        cfg_min_payload = s.min_payload;
        cfg_max_delay   = s.max_delay;
        cfg_min_count   = s.min_count;
        reg_check({REG_MIN_PAYLOAD, 2'b00}, s.min_payload);
        reg_check({REG_MAX_DELAY, 2'b00},   s.max_delay);
        reg_check({REG_MIN_COUNT, 2'b00},   s.min_count);
    endtask

    // ------------------------------------------------------------------
    // Receiver: check every transfer against the oldest owed verdict and
    // stall at random; one long hold-off fills the block and backs up the
    // sender.
    // ------------------------------------------------------------------
    initial
    begin
        int       stall_left;
        verdict_t got;
        verdict_t want;
        stall_left = 0;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                got = '{res.flood_detected, res.new_target, res.table_full};
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result with none owed: flood %b new %b full %b",
                             $time, got.flood_detected, got.new_target, got.table_full);
                    mismatches++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("flood_detected", want.flood_detected, got.flood_detected);
                    check_field("new_target", want.new_target, got.new_target);
                    check_field("table_full", want.table_full, got.table_full);
                end
            end
            if (hold_off_req)
            begin
                stall_left = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed plan, then random phases
    // ------------------------------------------------------------------
    initial
    begin
        ping_t       p;
        pfd_cfg_t    s;
        bit          counted;
        int          seen;
        int          step_max;
        int          room;
        int          payload;
        int          r;
        logic [47:0] clock_ms;
        logic [31:0] suspects [$];

        mismatches   = 0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;

        // Shadow state matches the block right after reset
        cfg_min_payload = MIN_PAYLOAD_RESET;
        cfg_max_delay   = MAX_DELAY_RESET;
        cfg_min_count   = MIN_COUNT_RESET;
        for (int i = 0; i < PFD_TABLE_ENTRIES; i++)
            tgt_valid[i] = 1'b0;

        // Hold every input at a known value from time zero
        rst_n            <= 1'b0;
        pkt.valid        <= 1'b0;
        pkt.icmp_type    <= '0;
        pkt.icmp_code    <= '0;
        pkt.total_length <= '0;
        pkt.hdr_len      <= '0;
        pkt.dest_ip      <= '0;
        pkt.arrival_ms   <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan. Typed verdicts are the obvious ones; the rest come
        // from the predictor.
        plan = '{
            // reset settings: exactly minimum payload makes a new entry
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd1032, 16'd8, IP_A, 48'd1000},
              1, 1'b1, V_NEW},
            // one byte short of the minimum
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd1031, 16'd8, IP_A, 48'd1001},
              1, 1'b1, V_QUIET},
            // echo reply, wrong code, negative payload, all-ones type and code
            '{1'b0, CFG_NONE, '{8'd0, ECHO_CODE, 16'd2000, 16'd8, IP_A, 48'd1002},
              1, 1'b1, V_QUIET},
            '{1'b0, CFG_NONE, '{ECHO_TYPE, 8'd1, 16'd2000, 16'd8, IP_A, 48'd1003},
              1, 1'b1, V_QUIET},
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd0, 16'hFFFF, IP_A, 48'd1004},
              1, 1'b1, V_QUIET},
            '{1'b0, CFG_NONE, '{8'hFF, 8'hFF, 16'hFFFF, 16'd0, IP_A, 48'd1005},
              1, 1'b1, V_QUIET},
            // known target, count far below one hundred
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd1032, 16'd8, IP_A, 48'd1010},
              1, 1'b1, V_QUIET},
            // zero minimum count, widest delay
            '{1'b1, '{16'd0, 16'hFFFF, 16'd0}, NO_PING, 0, 1'b0, V_QUIET},
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd0, 16'd0, IP_B, 48'hFFFF_FFFF_FFFF},
              1, 1'b1, V_NEW},
            // clock wraps by one tick: first known ping is a flood
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd0, 16'd0, IP_B, 48'd0},
              1, 1'b1, V_FLOOD},
            // time running backward wraps to huge gaps; the sum saturates
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd0, 16'd0, IP_A, 48'd5},
              1, 1'b0, V_QUIET},
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd0, 16'd0, IP_A, 48'd4},
              1, 1'b0, V_QUIET},
            // fill the rest of the table
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd64, 16'd8, BASE_D, 48'd100},
              PFD_TABLE_ENTRIES - 1, 1'b0, V_QUIET},
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd64, 16'd8, IP_C, 48'd100},
              1, 1'b1, V_FULL},
            // a flood frees an entry, which the refused target then takes
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd64, 16'd8, BASE_D, 48'd100},
              1, 1'b1, V_FLOOD},
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'd64, 16'd8, IP_C, 48'd200},
              1, 1'b1, V_NEW},
            // minimum payload and count at the top, delay limit zero: nothing can flood
            '{1'b1, '{16'hFFFF, 16'd0, 16'hFFFF}, NO_PING, 0, 1'b0, V_QUIET},
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'hFFFF, 16'd0, IP_A, 48'd300},
              1, 1'b1, V_QUIET},
            '{1'b0, CFG_NONE, '{ECHO_TYPE, ECHO_CODE, 16'hFFFF, 16'd1, IP_A, 48'd301},
              1, 1'b1, V_QUIET}
        };

        foreach (plan[i])
        begin
            if (plan[i].reconfig)
                apply_settings(plan[i].settings);
            else
            begin
                for (int k = 0; k < plan[i].reps; k++)
                begin
                    p = plan[i].ping;
                    p.dest_ip = p.dest_ip + 32'(k);
                    offer_ping(p, plan[i].typed, plan[i].given, counted);
                end
            end
        end

        // Random phases. Most pings are well-formed echo requests from a small
        // set of suspects on a running clock, so entries build up and flood;
        // the rest are unseen targets, clock jumps and garbage.
        clock_ms = 48'({$urandom(), $urandom()});
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                s = '{16'd0, 16'hFFFF, 16'd0};  // flush what the plan left behind
            else if (ph == PHASES - 1)
                s = '{MIN_PAYLOAD_RESET, MAX_DELAY_RESET, MIN_COUNT_RESET};
            else
            begin
                r = $urandom_range(0, 99);
                s.min_payload = (r < 20) ? 16'd0 : (r < 30) ? 16'hFFFF :
                                16'($urandom_range(0, 1500));
                r = $urandom_range(0, 99);
                s.max_delay = (r < 10) ? 16'd0 : (r < 25) ? 16'hFFFF :
                              16'($urandom_range(1, 400));
                r = $urandom_range(0, 99);
                s.min_count = (r < 15) ? 16'd0 : (r < 20) ? 16'hFFFF :
                              (r < 25) ? MIN_COUNT_RESET : 16'($urandom_range(1, 8));
            end
            apply_settings(s);

            quiet = ($urandom_range(0, 3) == 0);
            if (ph == 1)
                hold_off_req = 1'b1;
            step_max = $urandom_range(0, 60);

            // Suspects: plan leftovers and fresh addresses; large sets overflow the table
            suspects.delete();
            repeat ($urandom_range(2, 24))
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    suspects.push_back(BASE_D + 32'($urandom_range(0, PFD_TABLE_ENTRIES - 1)));
                else if (r < 50)
                    suspects.push_back(r[0] ? IP_A : IP_C);
                else
                    suspects.push_back($urandom());
            end

            seen = 0;
            while (seen < PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                p.icmp_type = ECHO_TYPE;
                p.icmp_code = ECHO_CODE;
                p.dest_ip = suspects[$urandom_range(0, suspects.size() - 1)];
                clock_ms += 48'($urandom_range(0, step_max));
                if (r == 0)
                    clock_ms += 48'({$urandom(), $urandom()});
                p.arrival_ms = clock_ms;
                room = 65535 - int'(cfg_min_payload);
                payload = int'(cfg_min_payload) + $urandom_range(0, (room < 64) ? room : 64);
                p.hdr_len = 16'($urandom_range(0, 65535 - payload));
                p.total_length = 16'(int'(p.hdr_len) + payload);
                if (r >= 92)
                begin
                    // garbage: any field may be off
                    p.icmp_type    = $urandom_range(0, 1) ? ECHO_TYPE : 8'($urandom());
                    p.icmp_code    = $urandom_range(0, 1) ? ECHO_CODE : 8'($urandom());
                    p.total_length = 16'($urandom());
                    p.hdr_len      = 16'($urandom());
                    p.dest_ip      = $urandom();
                    p.arrival_ms   = 48'({$urandom(), $urandom()});
                end
                else if (r >= 84)
                begin
                    // broken sequence: unseen target at an arbitrary time
                    p.dest_ip    = $urandom();
                    p.arrival_ms = 48'({$urandom(), $urandom()});
                end
                offer_ping(p, 1'b0, V_QUIET, counted);
                if (counted)
                    seen++;
            end
        end

        // Drop valid, wait for every owed verdict, then keep the clock running
        // to catch anything extra
        pkt.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (PFD_TABLE_ENTRIES + 8) @(posedge clk);
        if (mismatches == 0)
            $display("ping_flood_detector test passed");
        else
            $display("ping_flood_detector test failed");
        $finish;
    end

endmodule
